// ===== rtl/core/gcs_pkg.sv =====
package gcs_pkg;

  localparam int IN_FRAC_BITS = 4;

  localparam int GRAD_W   = 13;
  localparam int M_W      = 12;
  localparam int N_W      = 13;
  localparam int CFG_W    = 12;
  localparam int WEIGHT_W = 11;
  localparam int OUT_W    = 16;
  localparam int IDX_W    = 2;

  localparam int RATIO_BITS   = 30;
  localparam int WEIGHT_SHIFT = 10;
  localparam int OUT_FRAC     = 14;
  localparam int WEIGHT_ONE   = 1 << WEIGHT_SHIFT;

  localparam int K_W    = CFG_W + 2 * IN_FRAC_BITS;
  localparam int PROD_W = 2 * GRAD_W;
  localparam int DW     = ((K_W > PROD_W + 1) ? K_W : PROD_W + 1) + 1;
  localparam int Q_W    = RATIO_BITS + 1;
  localparam int RW     = Q_W + 1;
  localparam int ACC_W  = RW + 1 + WEIGHT_W + 1;
  localparam int SH     = RATIO_BITS + WEIGHT_SHIFT - OUT_FRAC;

  localparam int DIV_STAGES = Q_W;
  localparam int LANES      = 4;

  localparam logic [CFG_W-1:0]    RST_CONST_REF_DIST  = 12'd140;
  localparam logic [CFG_W-1:0]    RST_CONST_FUSED     = 12'd55;
  localparam logic [CFG_W-1:0]    RST_CONST_CHROMA    = 12'd550;
  localparam logic [WEIGHT_W-1:0] RST_GRADIENT_WEIGHT = 11'd614;

  typedef enum logic [IDX_W-1:0] {
    REG_CONST_REF_DIST,
    REG_CONST_FUSED,
    REG_CONST_CHROMA,
    REG_GRADIENT_WEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_tag_t;

endpackage

// ===== rtl/core/gcs_div_pipe.sv =====
module gcs_div_pipe (
  input  logic                       clk,
  input  logic [gcs_pkg::DW-1:0]     mag,
  input  logic [gcs_pkg::DW-1:0]     den,
  input  gcs_pkg::div_tag_t          tag_in,
  output logic [gcs_pkg::Q_W-1:0]    quo,
  output gcs_pkg::div_tag_t          tag_out
);

  localparam int S   = gcs_pkg::DIV_STAGES;
  localparam int DW  = gcs_pkg::DW;
  localparam int Q_W = gcs_pkg::Q_W;

  logic [DW-1:0]      rem_s [0:S];
  logic [DW-1:0]      den_s [0:S];
  logic [Q_W-1:0]     low_s [0:S];
  logic [Q_W-1:0]     q_s   [0:S];
  gcs_pkg::div_tag_t  tag_s [0:S];

  // dividend is mag * 2^30 + den/2, quotient known to fit in Q_W bits
  always_ff @(posedge clk) begin
    rem_s[0] <= mag >> 1;
    den_s[0] <= den;
    low_s[0] <= {mag[0], gcs_pkg::RATIO_BITS'(den >> 1)};
    q_s[0]   <= '0;
    tag_s[0] <= tag_in;
  end

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem_s[i], low_s[i][Q_W-1]};
    assign diff  = trial - {1'b0, den_s[i]};
    assign ge    = trial >= {1'b0, den_s[i]};
    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_s[i+1]   <= {q_s[i][Q_W-2:0], ge};
      low_s[i+1] <= low_s[i] << 1;
      den_s[i+1] <= den_s[i];
      tag_s[i+1] <= tag_s[i];
    end
  end

  assign quo     = q_s[S];
  assign tag_out = tag_s[S];

endmodule

// ===== rtl/core/gradient_chroma_similarity.sv =====
// Fully pipelined: one pixel may be started in every cycle (busy stays low) and its
// similarity appears with done once it has passed the product, sum, magnitude, divider,
// ratio, blend and rounding registers; the four restoring dividers run side by side,
// each a setup stage followed by 31 stages of one quotient bit a stage.
// The receiver cannot stall, so every done beat must be taken when it is shown.
// Configuration writes are always ready and must only be made while no pixel is in flight.
module gradient_chroma_similarity (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gcs_pkg::GRAD_W-1:0]          grad_ref,
  input  logic [gcs_pkg::GRAD_W-1:0]          grad_dist,
  input  logic [gcs_pkg::GRAD_W-1:0]          grad_fused,
  input  logic signed [gcs_pkg::M_W-1:0]      chroma_m_ref,
  input  logic signed [gcs_pkg::M_W-1:0]      chroma_m_dist,
  input  logic signed [gcs_pkg::N_W-1:0]      chroma_n_ref,
  input  logic signed [gcs_pkg::N_W-1:0]      chroma_n_dist,
  output logic                                done,
  output logic signed [gcs_pkg::OUT_W-1:0]    similarity,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcs_pkg::IDX_W-1:0]           cfg_index,
  input  logic [gcs_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DW      = gcs_pkg::DW;
  localparam int RW      = gcs_pkg::RW;
  localparam int Q_W     = gcs_pkg::Q_W;
  localparam int ACC_W   = gcs_pkg::ACC_W;
  localparam int PROD_W  = gcs_pkg::PROD_W;
  localparam int CW      = DW + 1;
  localparam int KSH     = 2 * gcs_pkg::IN_FRAC_BITS;
  localparam int LANES   = gcs_pkg::LANES;
  localparam int VLD_LEN = gcs_pkg::DIV_STAGES + 9;
  localparam int RATIO_AT = gcs_pkg::DIV_STAGES + 4;

  localparam int LANE_RD = 0;
  localparam int LANE_RF = 1;
  localparam int LANE_DF = 2;
  localparam int LANE_CS = 3;

  localparam logic signed [RW-1:0] ONE_R = RW'(64'(1) << gcs_pkg::RATIO_BITS);
  localparam logic signed [ACC_W-1:0] BIAS_P = ACC_W'(64'(1) << (gcs_pkg::SH - 1));
  localparam logic signed [ACC_W-1:0] BIAS_N = ACC_W'((64'(1) << (gcs_pkg::SH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'(1) << (gcs_pkg::OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'(1) << (gcs_pkg::OUT_W - 1));

  logic [gcs_pkg::CFG_W-1:0]    const_ref_dist;
  logic [gcs_pkg::CFG_W-1:0]    const_fused;
  logic [gcs_pkg::CFG_W-1:0]    const_chroma;
  logic [gcs_pkg::WEIGHT_W-1:0] gradient_weight;

  logic                accept;
  logic [VLD_LEN-1:0]  vld;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      const_ref_dist  <= gcs_pkg::RST_CONST_REF_DIST;
      const_fused     <= gcs_pkg::RST_CONST_FUSED;
      const_chroma    <= gcs_pkg::RST_CONST_CHROMA;
      gradient_weight <= gcs_pkg::RST_GRADIENT_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (gcs_pkg::cfg_reg_t'(cfg_index))
        gcs_pkg::REG_CONST_REF_DIST:  const_ref_dist  <= cfg_data;
        gcs_pkg::REG_CONST_FUSED:     const_fused     <= cfg_data;
        gcs_pkg::REG_CONST_CHROMA:    const_chroma    <= cfg_data;
        gcs_pkg::REG_GRADIENT_WEIGHT: gradient_weight <= cfg_data[gcs_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[VLD_LEN-2:0], accept};
    end
  end

  // products
  logic [PROD_W-1:0] p_rd, p_rf, p_df, p_rr, p_dd, p_ff;
  logic signed [2*gcs_pkg::M_W-1:0] c_mm, c_mr2, c_md2;
  logic signed [2*gcs_pkg::N_W-1:0] c_nn, c_nr2, c_nd2;

  always_ff @(posedge clk) begin
    p_rd  <= PROD_W'(grad_ref) * PROD_W'(grad_dist);
    p_rf  <= PROD_W'(grad_ref) * PROD_W'(grad_fused);
    p_df  <= PROD_W'(grad_dist) * PROD_W'(grad_fused);
    p_rr  <= PROD_W'(grad_ref) * PROD_W'(grad_ref);
    p_dd  <= PROD_W'(grad_dist) * PROD_W'(grad_dist);
    p_ff  <= PROD_W'(grad_fused) * PROD_W'(grad_fused);
    c_mm  <= (2*gcs_pkg::M_W)'(chroma_m_ref) * (2*gcs_pkg::M_W)'(chroma_m_dist);
    c_mr2 <= (2*gcs_pkg::M_W)'(chroma_m_ref) * (2*gcs_pkg::M_W)'(chroma_m_ref);
    c_md2 <= (2*gcs_pkg::M_W)'(chroma_m_dist) * (2*gcs_pkg::M_W)'(chroma_m_dist);
    c_nn  <= (2*gcs_pkg::N_W)'(chroma_n_ref) * (2*gcs_pkg::N_W)'(chroma_n_dist);
    c_nr2 <= (2*gcs_pkg::N_W)'(chroma_n_ref) * (2*gcs_pkg::N_W)'(chroma_n_ref);
    c_nd2 <= (2*gcs_pkg::N_W)'(chroma_n_dist) * (2*gcs_pkg::N_W)'(chroma_n_dist);
  end

  // numerators and denominators
  logic [DW-1:0] k1, k2, k3;
  logic [DW-1:0] num2 [0:LANES-2];
  logic [DW-1:0] den2 [0:LANES-1];
  logic signed [CW-1:0] cnum2;

  assign k1 = DW'(const_ref_dist) << KSH;
  assign k2 = DW'(const_fused) << KSH;
  assign k3 = DW'(const_chroma) << KSH;

  always_ff @(posedge clk) begin
    num2[LANE_RD] <= (DW'(p_rd) << 1) + k1;
    den2[LANE_RD] <= DW'(p_rr) + DW'(p_dd) + k1;
    num2[LANE_RF] <= (DW'(p_rf) << 1) + k2;
    den2[LANE_RF] <= DW'(p_rr) + DW'(p_ff) + k2;
    num2[LANE_DF] <= (DW'(p_df) << 1) + k2;
    den2[LANE_DF] <= DW'(p_dd) + DW'(p_ff) + k2;
    cnum2 <= ((CW'(c_mm) + CW'(c_nn)) <<< 1) + $signed({1'b0, k3});
    den2[LANE_CS] <= DW'(c_mr2) + DW'(c_md2) + DW'(c_nr2) + DW'(c_nd2) + k3;
  end

  // magnitude and sign for the dividers
  logic [DW-1:0]     mag3 [0:LANES-1];
  logic [DW-1:0]     den3 [0:LANES-1];
  gcs_pkg::div_tag_t tag3 [0:LANES-1];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES - 1; l++) begin
      mag3[l]      <= num2[l];
      den3[l]      <= den2[l];
      tag3[l].neg  <= 1'b0;
      tag3[l].zero <= den2[l] == '0;
    end
    mag3[LANE_CS]      <= cnum2[CW-1] ? DW'(-cnum2) : cnum2[DW-1:0];
    den3[LANE_CS]      <= den2[LANE_CS];
    tag3[LANE_CS].neg  <= cnum2[CW-1];
    tag3[LANE_CS].zero <= den2[LANE_CS] == '0;
  end

  logic [Q_W-1:0]    quo  [0:LANES-1];
  gcs_pkg::div_tag_t tagq [0:LANES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    gcs_div_pipe u_div (
      .clk     (clk),
      .mag     (mag3[l]),
      .den     (den3[l]),
      .tag_in  (tag3[l]),
      .quo     (quo[l]),
      .tag_out (tagq[l])
    );
  end

  // signed ratios, zero denominator means identical values
  logic signed [RW-1:0] ratio [0:LANES-1];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (tagq[l].zero) begin
        ratio[l] <= ONE_R;
      end else if (tagq[l].neg) begin
        ratio[l] <= -$signed({1'b0, quo[l]});
      end else begin
        ratio[l] <= $signed({1'b0, quo[l]});
      end
    end
  end

  logic signed [RW:0]             gs;
  logic signed [RW-1:0]           cs;
  logic [gcs_pkg::WEIGHT_W-1:0]   alpha;
  logic [gcs_pkg::WEIGHT_W-1:0]   beta;

  always_ff @(posedge clk) begin
    gs <= (RW+1)'(ratio[LANE_RD]) + (RW+1)'(ratio[LANE_RF]) - (RW+1)'(ratio[LANE_DF]);
    cs <= ratio[LANE_CS];
    if (gradient_weight > gcs_pkg::WEIGHT_W'(gcs_pkg::WEIGHT_ONE)) begin
      alpha <= gcs_pkg::WEIGHT_W'(gcs_pkg::WEIGHT_ONE);
      beta  <= '0;
    end else begin
      alpha <= gradient_weight;
      beta  <= gcs_pkg::WEIGHT_W'(gcs_pkg::WEIGHT_ONE) - gradient_weight;
    end
  end

  logic signed [ACC_W-1:0] pa, pb, acc;

  always_ff @(posedge clk) begin
    pa  <= ACC_W'(gs) * ACC_W'($signed({1'b0, alpha}));
    pb  <= ACC_W'(cs) * ACC_W'($signed({1'b0, beta}));
    acc <= pa + pb;
  end

  // round to nearest, ties away from zero, then saturate
  logic signed [ACC_W-1:0] rq;

  assign rq = (acc + (acc[ACC_W-1] ? BIAS_N : BIAS_P)) >>> gcs_pkg::SH;

  always_ff @(posedge clk) begin
    if (rq > SAT_HI) begin
      similarity <= SAT_HI[gcs_pkg::OUT_W-1:0];
    end else if (rq < SAT_LO) begin
      similarity <= SAT_LO[gcs_pkg::OUT_W-1:0];
    end else begin
      similarity <= rq[gcs_pkg::OUT_W-1:0];
    end
  end

  assign done = vld[VLD_LEN-1];

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, VLD_LEN))
    else $error("done without a matching start beat");

  a_chroma_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    vld[RATIO_AT] |-> (ratio[LANE_CS] <= ONE_R) && (ratio[LANE_CS] >= -ONE_R))
    else $error("chroma ratio out of unit range");

  a_grad_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    vld[RATIO_AT] |-> !ratio[LANE_DF][RW-1] && (ratio[LANE_DF] <= ONE_R)
                      && !ratio[LANE_RD][RW-1] && (ratio[LANE_RD] <= ONE_R))
    else $error("gradient ratio out of unit range");

endmodule

// ===== sim/gradient_chroma_similarity_test.sv =====
module gradient_chroma_similarity_test;

  typedef struct {
    logic [gcs_pkg::GRAD_W-1:0] gr, gd, gf;
    logic [gcs_pkg::M_W-1:0]    mr, md;
    logic [gcs_pkg::N_W-1:0]    nr, nd;
    bit                         typed;
    logic [gcs_pkg::OUT_W-1:0]  sim;
  } pixel_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, cfg_ready;
  logic [gcs_pkg::GRAD_W-1:0] grad_ref = 0, grad_dist = 0, grad_fused = 0;
  logic signed [gcs_pkg::M_W-1:0] chroma_m_ref = 0, chroma_m_dist = 0;
  logic signed [gcs_pkg::N_W-1:0] chroma_n_ref = 0, chroma_n_dist = 0;
  logic signed [gcs_pkg::OUT_W-1:0] similarity;
  logic cfg_valid = 0;
  logic [gcs_pkg::IDX_W-1:0] cfg_index = 0;
  logic [gcs_pkg::CFG_W-1:0] cfg_data = 0;

  logic [gcs_pkg::CFG_W-1:0]    stab_rd, stab_fused, stab_chroma;
  logic [gcs_pkg::WEIGHT_W-1:0] alpha_w;

  logic [gcs_pkg::OUT_W-1:0] pending_sim[$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;

  gradient_chroma_similarity uut (.*);

  always #1 clk = ~clk;

  function automatic longint q30_of(longint num, longint den);
    longint mag, q;
    if (den == 0) return longint'(1) << gcs_pkg::RATIO_BITS;
    mag = num < 0 ? -num : num;
    q = ((mag << gcs_pkg::RATIO_BITS) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint grad_ratio(longint a, longint b, longint c);
    longint k;
    k = c << (2 * gcs_pkg::IN_FRAC_BITS);
    return q30_of(2 * a * b + k, a * a + b * b + k);
  endfunction

  function automatic logic [gcs_pkg::OUT_W-1:0] predict_similarity(pixel_row_t p);
    longint gr, gd, gf, mr, md, nr, nd, k3, cs, gs, alpha, acc, mag, q, res;
    gr = p.gr;
    gd = p.gd;
    gf = p.gf;
    mr = $signed(p.mr);
    md = $signed(p.md);
    nr = $signed(p.nr);
    nd = $signed(p.nd);
    gs = grad_ratio(gr, gd, stab_rd) + grad_ratio(gr, gf, stab_fused)
       - grad_ratio(gd, gf, stab_fused);
    k3 = longint'(stab_chroma) << (2 * gcs_pkg::IN_FRAC_BITS);
    cs = q30_of(2 * (mr * md + nr * nd) + k3, mr * mr + md * md + nr * nr + nd * nd + k3);
    alpha = alpha_w > gcs_pkg::WEIGHT_ONE ? gcs_pkg::WEIGHT_ONE : alpha_w;
    acc = alpha * gs + (gcs_pkg::WEIGHT_ONE - alpha) * cs;
    mag = acc < 0 ? -acc : acc;
    q = (mag + (longint'(1) << (gcs_pkg::SH - 1))) >>> gcs_pkg::SH;
    if (q > 32768) q = 32768;
    res = acc < 0 ? -q : q;
    if (res > 32767) res = 32767;
    return res[gcs_pkg::OUT_W-1:0];
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending_sim.size() == 0) begin
        $error("similarity: unexpected result %0d", similarity);
        errors++;
      end else begin
        if (similarity !== pending_sim[0]) begin
          $error("similarity: expected %0d, got %0d", $signed(pending_sim[0]), similarity);
          errors++;
        end
        void'(pending_sim.pop_front());
      end
    end
  end

  task automatic send_pixel(pixel_row_t p);
    @(negedge clk);
    start = 1;
    grad_ref = p.gr;
    grad_dist = p.gd;
    grad_fused = p.gf;
    chroma_m_ref = p.mr;
    chroma_m_dist = p.md;
    chroma_n_ref = p.nr;
    chroma_n_dist = p.nd;
    do @(posedge clk); while (busy);
    pending_sim.push_back(p.typed ? p.sim : predict_similarity(p));
    pixels_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start = 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    idle_cycles(1);
    while (pending_sim.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(gcs_pkg::cfg_reg_t idx, logic [gcs_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gcs_pkg::REG_CONST_REF_DIST:  stab_rd = value;
      gcs_pkg::REG_CONST_FUSED:     stab_fused = value;
      gcs_pkg::REG_CONST_CHROMA:    stab_chroma = value;
      gcs_pkg::REG_GRADIENT_WEIGHT: alpha_w = value[gcs_pkg::WEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic configure(int c1, int c2, int c3, int w);
    drain();
    write_reg(gcs_pkg::REG_CONST_REF_DIST, c1[gcs_pkg::CFG_W-1:0]);
    write_reg(gcs_pkg::REG_CONST_FUSED, c2[gcs_pkg::CFG_W-1:0]);
    write_reg(gcs_pkg::REG_CONST_CHROMA, c3[gcs_pkg::CFG_W-1:0]);
    write_reg(gcs_pkg::REG_GRADIENT_WEIGHT, w[gcs_pkg::CFG_W-1:0]);
  endtask

  function automatic pixel_row_t random_pixel();
    pixel_row_t p;
    int kind;
    kind = $urandom_range(99);
    p.typed = 0;
    p.sim = 0;
    if (kind < 15) begin
      p.gr = $urandom; p.gd = $urandom; p.gf = $urandom;
      p.mr = $urandom; p.md = $urandom; p.nr = $urandom; p.nd = $urandom;
    end else begin
      p.gr = $urandom_range(5776); p.gd = $urandom_range(5776); p.gf = $urandom_range(5776);
      p.mr = $urandom_range(2816) - 1428; p.md = $urandom_range(2816) - 1428;
      p.nr = $urandom_range(4529) - 2448; p.nd = $urandom_range(4529) - 2448;
      if (kind < 30) begin
        p.gd = p.gr; p.md = p.mr; p.nd = p.nr;
      end else if (kind < 40) begin
        p.md = -p.mr; p.nd = -p.nr;
      end else if (kind < 50) begin
        p.gr = $urandom_range(15); p.gd = $urandom_range(15); p.gf = $urandom_range(15);
        p.mr = $urandom_range(15) - 8; p.md = $urandom_range(15) - 8;
        p.nr = $urandom_range(15) - 8; p.nd = $urandom_range(15) - 8;
      end else if (kind < 55) begin
        p = '{default: 0};
      end
    end
    return p;
  endfunction

  task automatic random_run(int count);
    repeat (count) begin
      send_pixel(random_pixel());
      if ($urandom_range(3) == 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    pixel_row_t directed_rows[14];
    directed_rows = '{
      // all zero at reset stabilizers gives exactly one
      '{0, 0, 0, 0, 0, 0, 0, 1, 16'd16384},
      '{5776, 5776, 5776, 1388, 1388, 2081, 2081, 1, 16'd16384},
      '{100, 100, 100, -1428, -1428, -2448, -2448, 1, 16'd16384},
      '{8191, 8191, 8191, 2047, 2047, 4095, 4095, 1, 16'd16384},
      '{8191, 0, 0, -2048, 2047, -4096, 4095, 0, 0},
      '{0, 8191, 8191, 2047, -2048, 4095, -4096, 0, 0},
      '{5776, 0, 5776, 1388, -1388, 2081, -2081, 0, 0},
      '{0, 5776, 0, -1428, 1388, -2448, 2081, 0, 0},
      '{5776, 5776, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 5776, 1388, 0, 0, 2081, 0, 0},
      '{1, 2, 3, -1, 1, -1, 1, 0, 0},
      '{4096, 2048, 1024, -2048, -2048, -4096, -4096, 0, 0},
      '{3000, 200, 1500, 700, -300, -1200, 900, 0, 0},
      '{8191, 8191, 0, -2048, -2048, -4096, -4096, 0, 0}
    };
    stab_rd = gcs_pkg::RST_CONST_REF_DIST;
    stab_fused = gcs_pkg::RST_CONST_FUSED;
    stab_chroma = gcs_pkg::RST_CONST_CHROMA;
    alpha_w = gcs_pkg::RST_GRADIENT_WEIGHT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed_rows[i]) send_pixel(directed_rows[i]);
    random_run(150);
    // sender holds off until the pipe is empty
    drain();
    random_run(100);

    // zero stabilizers: all-zero pixels hit the zero denominator case
    configure(0, 0, 0, 1024);
    send_pixel(directed_rows[0]);
    send_pixel('{0, 0, 0, 0, 0, 5, -5, 0, 0});
    send_pixel('{0, 0, 0, 7, -7, 0, 0, 0, 0});
    random_run(180);
    configure(4095, 4095, 4095, 2047);
    random_run(180);
    configure(0, 4095, 0, 0);
    random_run(180);
    configure(4095, 0, 4095, 1025);
    random_run(180);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
              $urandom_range(1024));
    random_run(180);
    configure(gcs_pkg::RST_CONST_REF_DIST, gcs_pkg::RST_CONST_FUSED,
              gcs_pkg::RST_CONST_CHROMA, 512);
    random_run(180);

    drain();
    if (pending_sim.size() != 0) begin
      $error("similarity: %0d results never arrived", pending_sim.size());
      errors++;
    end
    $display("%0d pixels over 7 register settings incl. zero and full stabilizers,", pixels_sent);
    $display("weights 0, 512, 614, 1024 and above; %0d results checked", results_seen);
    if (errors == 0)
      $display("gradient_chroma_similarity: match");
    else
      $display("gradient_chroma_similarity: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("gradient_chroma_similarity: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gcs_pkg.sv
rtl/core/gcs_div_pipe.sv
rtl/core/gradient_chroma_similarity.sv
sim/gradient_chroma_similarity_test.sv
